/* hdl/kvt_pkg.sv */
// Shared types and codes for the integer key/value table.
package kvt_pkg;

	localparam int KEY_W   = 32;
	localparam int DATA_W  = 32;
	localparam int COUNT_W = 5;

	// Operation codes on the func port.
	localparam logic [1:0] OP_SET    = 2'd0;
	localparam logic [1:0] OP_GET    = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_FOUND  = 2'd0;
	localparam logic [1:0] ST_ABSENT = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	// A classified request as it travels from the front to the back.
	// No flag set means an unused operation code, which changes nothing.
	typedef struct packed {
		logic              do_set;
		logic              do_get;
		logic              do_remove;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] value;
	} req_t;

endpackage

/* hdl/kvt_front.sv */
// Front end: accepts items, decodes the operation and queues them for the back end.
module kvt_front import kvt_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               func,
	input  logic signed [KEY_W-1:0]  key,
	input  logic [DATA_W-1:0]        value_in,
	output logic                     req_valid,
	output req_t                     req,
	input  logic                     req_pop
);

	localparam int QD = 2;

	req_t       mem_q [QD];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	req_t       req_d;
	logic       push;

	always_comb begin
		req_d           = '0;
		req_d.do_set    = (func == OP_SET);
		req_d.do_get    = (func == OP_GET);
		req_d.do_remove = (func == OP_REMOVE);
		req_d.key       = key;
		req_d.value     = value_in;
	end

	assign in_stall  = (cnt_q == 2'(QD));
	assign push      = in_valid && !in_stall;
	assign req_valid = (cnt_q != 2'd0);
	assign req       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= req_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (req_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(req_pop);
		end
	end

endmodule

/* hdl/kvt_back.sv */
// Back end: the row of key/value cells, the match and update sequence and the result register.
module kvt_back import kvt_pkg::*; #(
	parameter int TABLE_DEPTH = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  req_t               req,
	output logic               req_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [DATA_W-1:0]  value_out,
	output logic [COUNT_W-1:0] entry_count
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int EW = (CW > COUNT_W) ? CW : COUNT_W;

	localparam logic S_FETCH = 1'b0;
	localparam logic S_EXEC  = 1'b1;

	logic [KEY_W-1:0]       key_q  [TABLE_DEPTH];
	logic [VALUE_WIDTH-1:0] val_q  [TABLE_DEPTH];
	logic [KEY_W-1:0]       key_up [TABLE_DEPTH];
	logic [VALUE_WIDTH-1:0] val_up [TABLE_DEPTH];
	logic [CW-1:0]          count_q;
	logic                   state_q;
	req_t                   req_s1;
	logic [TABLE_DEPTH-1:0] match_d;
	logic [TABLE_DEPTH-1:0] match_s1;

	logic                   out_valid_q;
	logic [1:0]             status_q;
	logic [DATA_W-1:0]      value_q;
	logic [COUNT_W-1:0]     count_out_q;

	logic                   exec_en;
	logic                   hit;
	logic [IW-1:0]          hit_idx;
	logic                   has_room;
	logic                   set_hit;
	logic                   set_ins;
	logic                   rem_hit;
	logic [VALUE_WIDTH-1:0] get_val;
	logic [VALUE_WIDTH-1:0] wr_val;
	logic [63:0]            vin_ext;
	logic [63:0]            vout_ext;
	logic [1:0]             status_d;
	logic [CW-1:0]          count_d;
	logic [EW-1:0]          count_ext;

	// Per-cell compare against the waiting request; cells at or above the count never match.
	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			match_d[i] = (key_q[i] == req.key) && (CW'(i) < count_q);
		end
	end

	assign req_pop = (state_q == S_FETCH) && req_valid;
	assign exec_en = (state_q == S_EXEC) && (!out_valid_q || !out_stall);

	always_comb begin
		hit_idx = '0;
		get_val = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (match_s1[i]) begin
				hit_idx = hit_idx | IW'(i);
				get_val = get_val | val_q[i];
			end
		end
	end

	assign hit      = |match_s1;
	assign has_room = (count_q < CW'(TABLE_DEPTH));
	assign set_hit  = req_s1.do_set && hit;
	assign set_ins  = req_s1.do_set && !hit && has_room;
	assign rem_hit  = req_s1.do_remove && hit;
	assign vin_ext  = 64'(req_s1.value);
	assign wr_val   = vin_ext[VALUE_WIDTH-1:0];

	always_comb begin
		status_d = ST_ABSENT;
		if (req_s1.do_set) begin
			if (hit) begin
				status_d = ST_FOUND;
			end else if (has_room) begin
				status_d = ST_ABSENT;
			end else begin
				status_d = ST_FULL;
			end
		end else if (req_s1.do_get || req_s1.do_remove) begin
			status_d = hit ? ST_FOUND : ST_ABSENT;
		end
	end

	always_comb begin
		count_d = count_q;
		if (set_ins) begin
			count_d = count_q + CW'(1);
		end else if (rem_hit) begin
			count_d = count_q - CW'(1);
		end
	end

	assign count_ext = EW'(count_d);
	assign vout_ext  = (req_s1.do_get && hit) ? 64'(get_val) : 64'd0;

	genvar g;
	generate
		for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
			if (g < TABLE_DEPTH - 1) begin : g_up
				assign key_up[g] = key_q[g + 1];
				assign val_up[g] = val_q[g + 1];
			end else begin : g_top
				assign key_up[g] = key_q[g];
				assign val_up[g] = val_q[g];
			end

			always_ff @(posedge clk) begin
				if (exec_en) begin
					if (set_hit && match_s1[g]) begin
						val_q[g] <= wr_val;
					end else if (set_ins && (CW'(g) == count_q)) begin
						key_q[g] <= req_s1.key;
						val_q[g] <= wr_val;
					end else if (rem_hit && (IW'(g) >= hit_idx)) begin
						key_q[g] <= key_up[g];
						val_q[g] <= val_up[g];
					end
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (req_pop) begin
			req_s1   <= req;
			match_s1 <= match_d;
		end
		if (exec_en) begin
			status_q    <= status_d;
			value_q     <= vout_ext[DATA_W-1:0];
			count_out_q <= count_ext[COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_FETCH;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_FETCH: begin
					if (req_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (exec_en) begin
						state_q <= S_FETCH;
					end
				end
				default: begin
					state_q <= S_FETCH;
				end
			endcase
			if (exec_en) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign value_out   = value_q;
	assign entry_count = count_out_q;

endmodule

/* hdl/int_key_value_table.sv */
// Top level of the integer key/value table.
// A small associative table of unique signed 32-bit keys, each with a value
// handle, kept in insertion order. Each item is a set (func 0), get (func 1)
// or remove (func 2); code 3 changes nothing. Every item yields exactly one
// result carrying a status (0 found, 1 absent or inserted, 2 set rejected
// because the table is full), the value of the matching entry on a get hit
// (zero otherwise), and the number of entries held after the item. Items
// enter a two-entry queue in the front end, so the input side keeps taking
// items while the back end works or the output is stalled, until the queue
// is full. The back end handles each item in the fetch state, which compares
// the key against every occupied cell in parallel and registers the match
// vector, then in the exec state, which applies the update (overwrite,
// append, or shift the upper cells down by one to close the gap on a remove)
// and loads the result register. It takes no new item until the last
// one has loaded its result. An accepted item passes from the queue through
// the match registers into the result register, which drives the output.
// The count of entries resets to zero; cell contents need no clearing since
// only cells below the count are ever compared or read.
module int_key_value_table import kvt_pkg::*; #(
	parameter int TABLE_DEPTH = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               func,
	input  logic signed [KEY_W-1:0]  key,
	input  logic [DATA_W-1:0]        value_in,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [1:0]               status,
	output logic [DATA_W-1:0]        value_out,
	output logic [COUNT_W-1:0]       entry_count
);

	// Classified request leaving the queue.
	logic req_valid;
	req_t req;
	logic req_pop;

	// The front end decodes func and buffers items so that a busy back end
	// does not stall the input every cycle.
	kvt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.key       (key),
		.value_in  (value_in),
		.req_valid (req_valid),
		.req       (req),
		.req_pop   (req_pop)
	);

	// The back end holds the cells, carries out one item at a time and
	// registers the result, which waits there until the output takes it.
	kvt_back #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req         (req),
		.req_pop     (req_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.value_out   (value_out),
		.entry_count (entry_count)
	);

endmodule

/* hdl/kvt_checker.sv */
// Port-level checks for the integer key/value table, bound to the top level.
module kvt_checker import kvt_pkg::*; #(
	parameter int TABLE_DEPTH = 16
) (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         status,
	input logic [DATA_W-1:0]  value_out,
	input logic [COUNT_W-1:0] entry_count
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(value_out)
			&& $stable(entry_count))
		else $error("stalled result changed or dropped");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_FOUND) || (status == ST_ABSENT) || (status == ST_FULL))
		else $error("result status uses an unused code");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL) |-> entry_count == COUNT_W'(TABLE_DEPTH))
		else $error("full reported while the table has room");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_FOUND) |-> value_out == '0)
		else $error("value returned without a hit");

endmodule

bind int_key_value_table kvt_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_kvt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.value_out   (value_out),
	.entry_count (entry_count)
);
